// ===== hdl/pva_pkg.sv =====
`timescale 1ns / 1ps

package pva_pkg;

  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int FIELD_VW   = 4;
  localparam int MAX_W      = 5;
  localparam int RESULT_CAP = 16;
  localparam int MCNT_W     = 5;

  typedef enum logic [1:0] {
    REQ_NOTE_ON    = 2'd0,
    REQ_NOTE_OFF   = 2'd1,
    REQ_VOICE_IDLE = 2'd2,
    REQ_QUERY      = 2'd3
  } pva_req_t;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_STEAL   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_QUERY   = 2'd3
  } pva_act_t;

  // controller commands; reads share scan_rd
  typedef struct packed {
    logic accept;
    logic init;
    logic pop_rd;
    logic pop_wr;
    logic scan_rd;
    logic rm_chk;
    logic rm_end;
    logic no_chk;
    logic no_end;
    logic q_chk;
    logic q_end;
  } pva_cmd_t;

  typedef struct packed {
    pva_req_t req;
    logic     steal;
    logic     no_room;
    logic     ignore_idle;
    logic     scan_more;
    logic     out_free;
    logic     no_block;
    logic     hold_v;
  } pva_stat_t;

endpackage

// ===== hdl/poly_voice_allocator.sv =====
`timescale 1ns / 1ps

// Polyphonic voice allocator with oldest-voice stealing.
// Input channel (in_valid / in_stall) takes one request: note on, note off,
// voice idle or query. Result channel (out_valid / out_stall) carries start,
// steal, release and query-answer items; out_last marks the final item of a
// request. A note off with no busy voice on its note and a voice idle give
// no item.
// One request is handled at a time; in_stall is high from acceptance until
// the request is done. The age list sits in a single-port memory that is
// walked one busy voice at a time, with a read state and a check state for
// each. A note on that finds a free voice and a voice idle for a voice that
// is not busy do not walk it.
// A result waits in an output register; the next request can be accepted
// while it is still stalled, and processing only pauses when another result
// must be loaded. Items are never dropped or repeated.
// Reset (rst_n low, synchronous) and any cfg_we write return every voice to
// idle; no clearing pass is needed, the block is ready on the next cycle.
module poly_voice_allocator import pva_pkg::*; #(
  parameter int VOICES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [MAX_W-1:0]    cfg_max_voices,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  input  logic [NOTE_W-1:0]   in_note,
  input  logic [VEL_W-1:0]    in_velocity,
  input  logic [FIELD_VW-1:0] in_voice_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_action,
  output logic [FIELD_VW-1:0] out_voice,
  output logic [NOTE_W-1:0]   out_note,
  output logic [VEL_W-1:0]    out_velocity,
  output logic                out_last,
  output logic [FIELD_VW-1:0] out_oldest_voice,
  output logic [FIELD_VW-1:0] out_newest_voice,
  output logic [FIELD_VW-1:0] out_lowest_voice,
  output logic [FIELD_VW-1:0] out_highest_voice
);

  pva_cmd_t  cmd;
  pva_stat_t stat;

  pva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pva_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_max_voices    (cfg_max_voices),
    .in_req_type       (in_req_type),
    .in_note           (in_note),
    .in_velocity       (in_velocity),
    .in_voice_index    (in_voice_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_voice         (out_voice),
    .out_note          (out_note),
    .out_velocity      (out_velocity),
    .out_last          (out_last),
    .out_oldest_voice  (out_oldest_voice),
    .out_newest_voice  (out_newest_voice),
    .out_lowest_voice  (out_lowest_voice),
    .out_highest_voice (out_highest_voice),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

// ===== hdl/pva_ctrl.sv =====
`timescale 1ns / 1ps

module pva_ctrl import pva_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pva_stat_t stat,
  output pva_cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DISP   = 13'b0000000000010,
    S_POP_RD = 13'b0000000000100,
    S_POP_WR = 13'b0000000001000,
    S_RM_RD  = 13'b0000000010000,
    S_RM_CHK = 13'b0000000100000,
    S_RM_END = 13'b0000001000000,
    S_NO_RD  = 13'b0000010000000,
    S_NO_CHK = 13'b0000100000000,
    S_NO_END = 13'b0001000000000,
    S_Q_RD   = 13'b0010000000000,
    S_Q_CHK  = 13'b0100000000000,
    S_Q_END  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.init = 1'b1;
        case (stat.req)
          REQ_NOTE_ON: begin
            if (stat.steal) begin
              state_nxt = S_RM_RD;
            end else if (stat.no_room) begin
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_POP_RD;
            end
          end
          REQ_NOTE_OFF: state_nxt = S_NO_RD;
          REQ_VOICE_IDLE: begin
            state_nxt = stat.ignore_idle ? S_IDLE : S_RM_RD;
          end
          REQ_QUERY: state_nxt = S_Q_RD;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = S_POP_WR;
      end
      S_POP_WR: begin
        cmd.pop_wr = 1'b1;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_RM_RD: begin
        if (stat.scan_more) begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_RM_CHK;
        end else begin
          state_nxt = S_RM_END;
        end
      end
      S_RM_CHK: begin
        cmd.rm_chk = 1'b1;
        state_nxt  = S_RM_RD;
      end
      S_RM_END: begin
        cmd.rm_end = 1'b1;
        // a steal ends with a result, a freed voice does not
        if (stat.req != REQ_NOTE_ON || stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_NO_RD: begin
        if (stat.scan_more) begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_NO_CHK;
        end else begin
          state_nxt = S_NO_END;
        end
      end
      S_NO_CHK: begin
        cmd.no_chk = 1'b1;
        if (!stat.no_block) begin
          state_nxt = S_NO_RD;
        end
      end
      S_NO_END: begin
        cmd.no_end = 1'b1;
        if (!stat.hold_v || stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_Q_RD: begin
        if (stat.scan_more) begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_Q_CHK;
        end else begin
          state_nxt = S_Q_END;
        end
      end
      S_Q_CHK: begin
        cmd.q_chk = 1'b1;
        state_nxt = S_Q_RD;
      end
      S_Q_END: begin
        cmd.q_end = 1'b1;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/pva_dp.sv =====
`timescale 1ns / 1ps

module pva_dp import pva_pkg::*; #(
  parameter int VOICES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [MAX_W-1:0]    cfg_max_voices,
  input  logic [1:0]          in_req_type,
  input  logic [NOTE_W-1:0]   in_note,
  input  logic [VEL_W-1:0]    in_velocity,
  input  logic [FIELD_VW-1:0] in_voice_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_action,
  output logic [FIELD_VW-1:0] out_voice,
  output logic [NOTE_W-1:0]   out_note,
  output logic [VEL_W-1:0]    out_velocity,
  output logic                out_last,
  output logic [FIELD_VW-1:0] out_oldest_voice,
  output logic [FIELD_VW-1:0] out_newest_voice,
  output logic [FIELD_VW-1:0] out_lowest_voice,
  output logic [FIELD_VW-1:0] out_highest_voice,
  input  pva_cmd_t            cmd,
  output pva_stat_t           stat
);

  localparam int VIW   = $clog2(VOICES);
  localparam int CW    = $clog2(VOICES + 1);
  localparam int EW    = VIW + NOTE_W;
  localparam int RST_M = (VOICES < 16) ? VOICES : 16;

  // counts and clamped voice limit
  logic [CW-1:0]     m_r, busy_r, idle_r, lw_r;
  logic [VOICES-1:0] busy_bits_r;

  // latched request
  pva_req_t            req_r;
  logic [NOTE_W-1:0]   note_r;
  logic [VEL_W-1:0]    vel_r;
  logic [FIELD_VW-1:0] vi_r;

  // scan state
  logic [CW-1:0]     j_r;
  logic              found_r;
  logic [VIW-1:0]    victim_r;
  logic              hold_v_r;
  logic [VIW-1:0]    hold_voice_r;
  logic [MCNT_W-1:0] mcnt_r;
  logic [NOTE_W:0]   lnote_r;
  logic [NOTE_W-1:0] hnote_r;
  logic [VIW-1:0]    lo_r, hi_r, old_r, new_r;
  logic [CW-1:0]     pop_addr_r;

  // age list entries carry voice and note together
  logic [EW-1:0]  age_mem [VOICES];
  logic [EW-1:0]  age_q_r;
  logic [VIW-1:0] idle_mem [VOICES];
  logic [VIW-1:0] idle_q_r;

  // result register
  logic                out_valid_r;
  pva_act_t            out_action_r;
  logic [VIW-1:0]      out_voice_r;
  logic [NOTE_W-1:0]   out_note_r;
  logic [VEL_W-1:0]    out_vel_r;
  logic                out_last_r;
  logic [VIW-1:0]      out_o_r, out_n_r, out_l_r, out_h_r;

  logic [CW-1:0]      m_cfg;
  logic               out_free;
  logic               steal_mode;
  logic [VIW-1:0]     e_voice;
  logic [NOTE_W-1:0]  e_note;
  logic               match;
  logic               no_block;
  logic [VIW-1:0]     vi_idx;
  logic [VIW-1:0]     pop_v;
  logic [CW-1:0]      jm1, busy_m1, idle_m1;
  logic               age_we;
  logic [VIW-1:0]     age_wa;
  logic [EW-1:0]      age_wd;
  logic               rm_do;
  logic               out_ld;
  pva_act_t           ld_action;
  logic [VIW-1:0]     ld_voice;
  logic               ld_last;
  logic               ld_query;

  always_comb begin
    if (cfg_max_voices == '0) begin
      m_cfg = CW'(1);
    end else if (32'(cfg_max_voices) > 32'(VOICES)) begin
      m_cfg = CW'(VOICES);
    end else begin
      m_cfg = CW'(cfg_max_voices);
    end
  end

  assign out_free   = !out_valid_r || !out_stall;
  assign steal_mode = (req_r == REQ_NOTE_ON);
  assign e_voice    = age_q_r[EW-1:NOTE_W];
  assign e_note     = age_q_r[NOTE_W-1:0];
  assign match      = (e_note == note_r);
  assign no_block   = match && hold_v_r && !out_free;
  assign vi_idx     = VIW'(vi_r);
  assign jm1        = j_r - CW'(1);
  assign busy_m1    = busy_r - CW'(1);
  assign idle_m1    = idle_r - CW'(1);
  // stack slots below the low-water mark are unwritten and stand for their index
  assign pop_v      = (pop_addr_r < lw_r) ? pop_addr_r[VIW-1:0] : idle_q_r;
  assign rm_do      = cmd.rm_end && (!steal_mode || out_free);

  always_comb begin
    stat.req         = req_r;
    stat.steal       = (busy_r >= m_r) && (busy_r != '0);
    stat.no_room     = (idle_r == '0) || (busy_r >= CW'(VOICES));
    stat.ignore_idle = (32'(vi_r) >= 32'(m_r)) || !busy_bits_r[vi_idx];
    stat.scan_more   = (j_r < busy_r) &&
                       ((req_r != REQ_NOTE_OFF) || (32'(mcnt_r) < RESULT_CAP));
    stat.out_free    = out_free;
    stat.no_block    = no_block;
    stat.hold_v      = hold_v_r;
  end

  // age list write port
  always_comb begin
    age_we = 1'b0;
    age_wa = busy_r[VIW-1:0];
    age_wd = {pop_v, note_r};
    if (cmd.pop_wr && out_free) begin
      age_we = 1'b1;
    end else if (cmd.rm_chk && found_r) begin
      // shift entries behind the removed one down by one
      age_we = 1'b1;
      age_wa = jm1[VIW-1:0];
      age_wd = age_q_r;
    end else if (rm_do && steal_mode) begin
      age_we = 1'b1;
      age_wa = busy_m1[VIW-1:0];
      age_wd = {victim_r, note_r};
    end
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_wa] <= age_wd;
    end
    if (cmd.scan_rd) begin
      age_q_r <= age_mem[j_r[VIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rm_do && !steal_mode && (idle_r < CW'(VOICES))) begin
      idle_mem[idle_r[VIW-1:0]] <= vi_idx;
    end
    if (cmd.pop_rd) begin
      idle_q_r   <= idle_mem[idle_m1[VIW-1:0]];
      pop_addr_r <= idle_m1;
    end
  end

  // counts, busy flags and the voice limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r         <= CW'(RST_M);
      busy_r      <= '0;
      idle_r      <= CW'(RST_M);
      lw_r        <= CW'(RST_M);
      busy_bits_r <= '0;
    end else if (cfg_we) begin
      m_r         <= m_cfg;
      busy_r      <= '0;
      idle_r      <= m_cfg;
      lw_r        <= m_cfg;
      busy_bits_r <= '0;
    end else begin
      if (cmd.pop_wr && out_free) begin
        busy_r             <= busy_r + CW'(1);
        idle_r             <= pop_addr_r;
        busy_bits_r[pop_v] <= 1'b1;
        if (pop_addr_r < lw_r) begin
          lw_r <= pop_addr_r;
        end
      end
      if (rm_do && !steal_mode) begin
        busy_bits_r[vi_idx] <= 1'b0;
        if (found_r) begin
          busy_r <= busy_m1;
        end
        if (idle_r < CW'(VOICES)) begin
          idle_r <= idle_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r  <= pva_req_t'(in_req_type);
      note_r <= in_note;
      vel_r  <= in_velocity;
      vi_r   <= in_voice_index;
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r      <= '0;
      found_r  <= 1'b0;
      hold_v_r <= 1'b0;
      mcnt_r   <= '0;
    end else if (cmd.init) begin
      j_r      <= '0;
      found_r  <= 1'b0;
      hold_v_r <= 1'b0;
      mcnt_r   <= '0;
    end else begin
      if (cmd.rm_chk) begin
        j_r <= j_r + CW'(1);
        if (steal_mode ? (j_r == '0) : (e_voice == vi_idx)) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.no_chk && !no_block) begin
        j_r <= j_r + CW'(1);
        if (match) begin
          hold_v_r <= 1'b1;
          mcnt_r   <= mcnt_r + MCNT_W'(1);
        end
      end
      if (cmd.no_end && out_free) begin
        hold_v_r <= 1'b0;
      end
      if (cmd.q_chk) begin
        j_r <= j_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      lnote_r <= (NOTE_W+1)'(1 << NOTE_W);
      hnote_r <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
      old_r   <= '0;
      new_r   <= '0;
    end else begin
      if (cmd.rm_chk && (steal_mode ? (j_r == '0) : (e_voice == vi_idx))) begin
        victim_r <= e_voice;
      end
      if (cmd.no_chk && !no_block && match) begin
        hold_voice_r <= e_voice;
      end
      if (cmd.q_chk) begin
        // ties go to the later, newer voice
        if ({1'b0, e_note} <= lnote_r) begin
          lnote_r <= {1'b0, e_note};
          lo_r    <= e_voice;
        end
        if (e_note >= hnote_r) begin
          hnote_r <= e_note;
          hi_r    <= e_voice;
        end
        if (j_r == '0) begin
          old_r <= e_voice;
        end
        new_r <= e_voice;
      end
    end
  end

  // result selection
  always_comb begin
    out_ld    = 1'b0;
    ld_action = ACT_START;
    ld_voice  = pop_v;
    ld_last   = 1'b1;
    ld_query  = 1'b0;
    if (cmd.pop_wr && out_free) begin
      out_ld = 1'b1;
    end else if (rm_do && steal_mode) begin
      out_ld    = 1'b1;
      ld_action = ACT_STEAL;
      ld_voice  = victim_r;
    end else if (cmd.no_chk && !no_block && match && hold_v_r) begin
      out_ld    = 1'b1;
      ld_action = ACT_RELEASE;
      ld_voice  = hold_voice_r;
      ld_last   = 1'b0;
    end else if (cmd.no_end && hold_v_r && out_free) begin
      out_ld    = 1'b1;
      ld_action = ACT_RELEASE;
      ld_voice  = hold_voice_r;
    end else if (cmd.q_end && out_free) begin
      out_ld    = 1'b1;
      ld_action = ACT_QUERY;
      ld_voice  = '0;
      ld_query  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_action_r <= ld_action;
      out_voice_r  <= ld_voice;
      out_note_r   <= ld_query ? '0 : note_r;
      out_vel_r    <= ld_query ? '0 : vel_r;
      out_last_r   <= ld_last;
      out_o_r      <= ld_query ? old_r : '0;
      out_n_r      <= ld_query ? new_r : '0;
      out_l_r      <= ld_query ? lo_r : '0;
      out_h_r      <= ld_query ? hi_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_voice         = FIELD_VW'(out_voice_r);
  assign out_note          = out_note_r;
  assign out_velocity      = out_vel_r;
  assign out_last          = out_last_r;
  assign out_oldest_voice  = FIELD_VW'(out_o_r);
  assign out_newest_voice  = FIELD_VW'(out_n_r);
  assign out_lowest_voice  = FIELD_VW'(out_l_r);
  assign out_highest_voice = FIELD_VW'(out_h_r);

endmodule

// ===== bench/tb_poly_voice_allocator.sv =====
`timescale 1ns / 1ps

module tb_poly_voice_allocator;
  import pva_pkg::*;

  localparam int NV            = 16;
  localparam int SETTLE_CYCLES = 2 * NV + 16;
  localparam int RUN_LIMIT     = 300000;
  localparam int ITEMS_PER_SET = 6;
  localparam int DUE_DEPTH     = 64;

  typedef struct packed {
    pva_act_t             action;
    logic [FIELD_VW-1:0]  voice;
    logic [NOTE_W-1:0]    pitch;
    logic [VEL_W-1:0]     vel;
    logic                 last;
    logic [FIELD_VW-1:0]  oldest;
    logic [FIELD_VW-1:0]  newest;
    logic [FIELD_VW-1:0]  lowest;
    logic [FIELD_VW-1:0]  highest;
  } voice_cmd_t;

  typedef struct packed {
    logic                 is_cfg;
    pva_req_t             req;
    logic [NOTE_W-1:0]    note;
    logic [VEL_W-1:0]     vel;
    logic [FIELD_VW-1:0]  vi;
    logic [MAX_W-1:0]     max_val;
    logic                 typed;
    voice_cmd_t           want;
  } stim_row_t;

  localparam voice_cmd_t NO_CMD = '0;

  // directed rows; typed rows carry their result, the rest go through the allocator copy
  localparam int DIR_N = 26;
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    // voice count 16 after reset
    '{1'b0, REQ_QUERY, 7'd0, 7'd0, 4'd0, 5'd0, 1'b1,
      '{ACT_QUERY, 4'd0, 7'd0, 7'd0, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0}},
    '{1'b0, REQ_NOTE_ON, 7'd0, 7'd0, 4'd0, 5'd0, 1'b1,
      '{ACT_START, 4'd15, 7'd0, 7'd0, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0}},
    '{1'b0, REQ_NOTE_ON, 7'd127, 7'd127, 4'd0, 5'd0, 1'b1,
      '{ACT_START, 4'd14, 7'd127, 7'd127, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0}},
    '{1'b0, REQ_NOTE_ON, 7'd60, 7'd64, 4'd0, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_NOTE_ON, 7'd60, 7'd1, 4'd0, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_QUERY, 7'd0, 7'd0, 4'd0, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_NOTE_OFF, 7'd60, 7'd0, 4'd0, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_NOTE_OFF, 7'd61, 7'd0, 4'd0, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_VOICE_IDLE, 7'd0, 7'd0, 4'd13, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_VOICE_IDLE, 7'd0, 7'd0, 4'd13, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_NOTE_ON, 7'd5, 7'd33, 4'd0, 5'd0, 1'b0, NO_CMD},
    // zero count acts as one voice, so the second note steals
    '{1'b1, REQ_NOTE_ON, 7'd0, 7'd0, 4'd0, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_NOTE_ON, 7'd10, 7'd127, 4'd0, 5'd0, 1'b1,
      '{ACT_START, 4'd0, 7'd10, 7'd127, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0}},
    '{1'b0, REQ_NOTE_ON, 7'd20, 7'd3, 4'd0, 5'd0, 1'b1,
      '{ACT_STEAL, 4'd0, 7'd20, 7'd3, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0}},
    '{1'b0, REQ_VOICE_IDLE, 7'd0, 7'd0, 4'd15, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_NOTE_OFF, 7'd20, 7'd127, 4'd0, 5'd0, 1'b1,
      '{ACT_RELEASE, 4'd0, 7'd20, 7'd127, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0}},
    '{1'b0, REQ_VOICE_IDLE, 7'd0, 7'd0, 4'd0, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_QUERY, 7'd0, 7'd0, 4'd0, 5'd0, 1'b1,
      '{ACT_QUERY, 4'd0, 7'd0, 7'd0, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0}},
    // above range acts as the full voice count
    '{1'b1, REQ_NOTE_ON, 7'd0, 7'd0, 4'd0, 5'd31, 1'b0, NO_CMD},
    '{1'b0, REQ_NOTE_ON, 7'd127, 7'd0, 4'd0, 5'd0, 1'b1,
      '{ACT_START, 4'd15, 7'd127, 7'd0, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0}},
    '{1'b0, REQ_NOTE_ON, 7'd0, 7'd127, 4'd0, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_QUERY, 7'd0, 7'd0, 4'd0, 5'd0, 1'b0, NO_CMD},
    '{1'b1, REQ_NOTE_ON, 7'd0, 7'd0, 4'd0, 5'd1, 1'b0, NO_CMD},
    '{1'b0, REQ_NOTE_ON, 7'd64, 7'd64, 4'd0, 5'd0, 1'b1,
      '{ACT_START, 4'd0, 7'd64, 7'd64, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0}},
    '{1'b0, REQ_NOTE_OFF, 7'd64, 7'd0, 4'd0, 5'd0, 1'b0, NO_CMD},
    '{1'b0, REQ_QUERY, 7'd0, 7'd0, 4'd0, 5'd0, 1'b0, NO_CMD}
  };

  localparam logic [MAX_W-1:0] MAX_SETTINGS [7] = '{
    5'd4, 5'd16, 5'd2, 5'd0, 5'd31, 5'd9, 5'd16
  };

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                cfg_we         = 1'b0;
  logic [MAX_W-1:0]    cfg_max_voices = '0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [1:0]          in_req_type    = '0;
  logic [NOTE_W-1:0]   in_note        = '0;
  logic [VEL_W-1:0]    in_velocity    = '0;
  logic [FIELD_VW-1:0] in_voice_index = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [1:0]          out_action;
  logic [FIELD_VW-1:0] out_voice;
  logic [NOTE_W-1:0]   out_note;
  logic [VEL_W-1:0]    out_velocity;
  logic                out_last;
  logic [FIELD_VW-1:0] out_oldest_voice;
  logic [FIELD_VW-1:0] out_newest_voice;
  logic [FIELD_VW-1:0] out_lowest_voice;
  logic [FIELD_VW-1:0] out_highest_voice;

  poly_voice_allocator #(
    .VOICES(NV)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_max_voices   (cfg_max_voices),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_note          (in_note),
    .in_velocity      (in_velocity),
    .in_voice_index   (in_voice_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_action       (out_action),
    .out_voice        (out_voice),
    .out_note         (out_note),
    .out_velocity     (out_velocity),
    .out_last         (out_last),
    .out_oldest_voice (out_oldest_voice),
    .out_newest_voice (out_newest_voice),
    .out_lowest_voice (out_lowest_voice),
    .out_highest_voice(out_highest_voice)
  );

  // allocator state, kept alongside the block
  logic [MAX_W-1:0]    cur_max;
  logic [NOTE_W-1:0]   voice_pitch [NV];
  logic                voice_on    [NV];
  logic [FIELD_VW-1:0] age_order   [NV];
  logic [FIELD_VW-1:0] free_stack  [NV];
  int                  n_active;
  int                  n_free;

  // items of the current request, then the ring of items still owed by the block
  voice_cmd_t step_cmds [RESULT_CAP];
  int         n_step;
  logic       alloc_effect;
  voice_cmd_t due_cmds [DUE_DEPTH];
  int         due_wr = 0;
  int         due_rd = 0;

  int   mismatch_count = 0;
  int   cycle_count    = 0;
  int   burst_left     = 0;
  logic valid_up       = 1'b0;
  int   stall_mode     = 0;
  int   stall_span     = 0;

  function automatic int active_voices();
    if (cur_max == 0) return 1;
    if (cur_max > NV) return NV;
    return int'(cur_max);
  endfunction

  function automatic void clear_voices();
    int m;
    m = active_voices();
    for (int i = 0; i < NV; i++) begin
      voice_pitch[i] = '0;
      voice_on[i]    = 1'b0;
      age_order[i]   = '0;
      free_stack[i]  = (i < m) ? FIELD_VW'(i) : '0;
    end
    n_free   = m;
    n_active = 0;
  endfunction

  function automatic void drop_from_age(int v);
    int i, j;
    for (i = 0; i < n_active; i++) begin
      if (age_order[i] == v) begin
        for (j = i; j + 1 < n_active; j++) age_order[j] = age_order[j + 1];
        n_active--;
        return;
      end
    end
  endfunction

  function automatic voice_cmd_t make_cmd(pva_act_t act, int voice, int pitch, int vel,
                                          logic last, int o, int n, int l, int h);
    voice_cmd_t c;
    c.action  = act;
    c.voice   = FIELD_VW'(voice);
    c.pitch   = NOTE_W'(pitch);
    c.vel     = VEL_W'(vel);
    c.last    = last;
    c.oldest  = FIELD_VW'(o);
    c.newest  = FIELD_VW'(n);
    c.lowest  = FIELD_VW'(l);
    c.highest = FIELD_VW'(h);
    return c;
  endfunction

  function automatic void add_step_cmd(voice_cmd_t c);
    step_cmds[n_step] = c;
    n_step++;
  endfunction

  function automatic void add_due(voice_cmd_t c);
    due_cmds[due_wr % DUE_DEPTH] = c;
    due_wr++;
  endfunction

  // one request through the allocator: fills step_cmds, flags whether anything happened
  function automatic void voice_alloc_step(pva_req_t req, logic [NOTE_W-1:0] note,
                                           logic [VEL_W-1:0] vel, logic [FIELD_VW-1:0] vi);
    int m, i, v, lo_note, hi_note, old_v, new_v, lo_v, hi_v;
    m = active_voices();
    n_step = 0;
    alloc_effect = 1'b0;
    case (req)
      REQ_NOTE_ON: begin
        if (n_active >= m && n_active > 0) begin
          // all voices taken: restart the oldest and move it to newest
          v = int'(age_order[0]);
          drop_from_age(v);
          age_order[n_active] = FIELD_VW'(v);
          n_active++;
          voice_pitch[v] = note;
          add_step_cmd(make_cmd(ACT_STEAL, v, int'(note), int'(vel), 1'b1, 0, 0, 0, 0));
        end else if (n_free > 0 && n_active < NV) begin
          n_free--;
          v = int'(free_stack[n_free]);
          voice_on[v]    = 1'b1;
          voice_pitch[v] = note;
          age_order[n_active] = FIELD_VW'(v);
          n_active++;
          add_step_cmd(make_cmd(ACT_START, v, int'(note), int'(vel), 1'b1, 0, 0, 0, 0));
        end
      end
      REQ_NOTE_OFF: begin
        for (i = 0; i < n_active && n_step < RESULT_CAP; i++) begin
          v = int'(age_order[i]);
          if (voice_pitch[v] == note) begin
            add_step_cmd(make_cmd(ACT_RELEASE, v, int'(note), int'(vel), 1'b0,
                                  0, 0, 0, 0));
          end
        end
        if (n_step > 0) step_cmds[n_step - 1].last = 1'b1;
      end
      REQ_VOICE_IDLE: begin
        if (vi < m && voice_on[vi]) begin
          drop_from_age(int'(vi));
          voice_on[vi] = 1'b0;
          if (n_free < NV) begin
            free_stack[n_free] = vi;
            n_free++;
          end
          alloc_effect = 1'b1;
        end
      end
      default: begin
        old_v = 0;
        new_v = 0;
        lo_v  = 0;
        hi_v  = 0;
        if (n_active > 0) begin
          old_v   = int'(age_order[0]);
          new_v   = int'(age_order[n_active - 1]);
          lo_note = 128;
          hi_note = 0;
          // ties go to the newer voice
          for (i = 0; i < n_active; i++) begin
            v = int'(age_order[i]);
            if (int'(voice_pitch[v]) <= lo_note) begin
              lo_note = int'(voice_pitch[v]);
              lo_v    = v;
            end
            if (int'(voice_pitch[v]) >= hi_note) begin
              hi_note = int'(voice_pitch[v]);
              hi_v    = v;
            end
          end
        end
        add_step_cmd(make_cmd(ACT_QUERY, 0, 0, 0, 1'b1, old_v, new_v, lo_v, hi_v));
      end
    endcase
    if (n_step > 0) alloc_effect = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic drop_valid();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // present one item and hold it until taken
  task automatic send_item(input pva_req_t req, input logic [NOTE_W-1:0] note,
                           input logic [VEL_W-1:0] vel, input logic [FIELD_VW-1:0] vi,
                           input logic typed, input voice_cmd_t want, output logic hit);
    in_valid       <= 1'b1;
    valid_up       = 1'b1;
    in_req_type    <= req;
    in_note        <= note;
    in_velocity    <= vel;
    in_voice_index <= vi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    voice_alloc_step(req, note, vel, vi);
    hit = alloc_effect;
    if (typed) add_due(want);
    else for (int k = 0; k < n_step; k++) add_due(step_cmds[k]);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      drop_valid();
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(8, 24))
                                               : int'($urandom_range(0, 5));
    end
  endtask

  task automatic write_max_voices(input logic [MAX_W-1:0] value);
    drop_valid();
    while (due_wr != due_rd) @(posedge clk);
    // a voice idle or silent note off may still be walking the age list
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_max_voices <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_max = value;
    clear_voices();
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern: free-running, busy, mostly stalled or toggling
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= int'($urandom_range(0, 3));
      stall_span <= int'($urandom_range(16, 96));
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin : result_check
    voice_cmd_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (due_wr == due_rd) begin
        $error("unexpected item: action %0d voice %0d note %0d",
               out_action, out_voice, out_note);
        mismatch_count++;
      end else begin
        w = due_cmds[due_rd % DUE_DEPTH];
        due_rd++;
        check_field("action", 8'(w.action), 8'(out_action));
        check_field("voice", 8'(w.voice), 8'(out_voice));
        check_field("note", 8'(w.pitch), 8'(out_note));
        check_field("velocity", 8'(w.vel), 8'(out_velocity));
        check_field("last", 8'(w.last), 8'(out_last));
        check_field("oldest_voice", 8'(w.oldest), 8'(out_oldest_voice));
        check_field("newest_voice", 8'(w.newest), 8'(out_newest_voice));
        check_field("lowest_voice", 8'(w.lowest), 8'(out_lowest_voice));
        check_field("highest_voice", 8'(w.highest), 8'(out_highest_voice));
      end
    end
  end

  initial begin : stimulus
    logic              hit;
    int                counted;
    int                pick;
    int                m;
    logic [NOTE_W-1:0] note_base;
    logic [NOTE_W-1:0] chord_note;
    pva_req_t          req;
    logic [NOTE_W-1:0] note;
    logic [FIELD_VW-1:0] vi;

    cur_max = MAX_W'(NV);
    clear_voices();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].is_cfg) begin
        write_max_voices(DIR_ROWS[r].max_val);
      end else begin
        send_item(DIR_ROWS[r].req, DIR_ROWS[r].note, DIR_ROWS[r].vel, DIR_ROWS[r].vi,
                  DIR_ROWS[r].typed, DIR_ROWS[r].want, hit);
        pace_sender();
      end
    end

    foreach (MAX_SETTINGS[p]) begin
      write_max_voices(MAX_SETTINGS[p]);
      m = active_voices();
      if (m == NV) begin
        // every voice on one note, then one note off releases them all
        chord_note = NOTE_W'($urandom_range(0, 127));
        repeat (NV) begin
          send_item(REQ_NOTE_ON, chord_note, VEL_W'($urandom_range(0, 127)),
                    FIELD_VW'($urandom_range(0, 15)), 1'b0, NO_CMD, hit);
          pace_sender();
        end
        send_item(REQ_NOTE_OFF, chord_note, VEL_W'($urandom_range(0, 127)),
                  FIELD_VW'($urandom_range(0, 15)), 1'b0, NO_CMD, hit);
        pace_sender();
      end
      counted   = 0;
      note_base = NOTE_W'($urandom_range(0, 122));
      while (counted < ITEMS_PER_SET) begin
        pick = int'($urandom_range(0, 99));
        note = ($urandom_range(0, 19) == 0) ? NOTE_W'($urandom_range(0, 127))
                                            : note_base + NOTE_W'($urandom_range(0, 5));
        vi   = FIELD_VW'($urandom_range(0, 15));
        if (pick < 45) begin
          req = REQ_NOTE_ON;
        end else if (pick < 65) begin
          req = REQ_NOTE_OFF;
        end else if (pick < 85) begin
          req = REQ_VOICE_IDLE;
          vi  = FIELD_VW'($urandom_range(0, m - 1));
        end else if (pick < 93) begin
          req = REQ_QUERY;
        end else begin
          req = pva_req_t'($urandom_range(0, 3));
        end
        send_item(req, note, VEL_W'($urandom_range(0, 127)), vi, 1'b0, NO_CMD, hit);
        pace_sender();
        if (hit) counted++;
      end
    end

    drop_valid();
    while (due_wr != due_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
